// ===== design/csad_pkg.sv =====
package csad_pkg;

    // datapath width of the cordic cells, signed
    localparam int CW = 34;

    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CW-1:0] QUARTER_TURN    = 34'sd1073741824;
    localparam logic signed [CW-1:0] HALF_TURN_S     = 34'sd2147483648;
    localparam logic [30:0]          ONE_Q30         = 31'd1073741824;
    localparam logic [31:0]          HALF_TURN       = 32'h8000_0000;

    typedef enum logic [1:0] {
        CFG_CENTRE_RA   = 2'd0,
        CFG_CENTRE_DEC  = 2'd1,
        CFG_CONE_RADIUS = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 tag;
    } t_cordic;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] root;
        logic        tag;
    } t_root;

    // atan(2^-i) in turn * 2^32, truncated
    function automatic logic signed [CW-1:0] atan_at(input int i);
        logic signed [CW-1:0] v;
        case (i)
            0:  v = 34'sd536870912;
            1:  v = 34'sd316933405;
            2:  v = 34'sd167458907;
            3:  v = 34'sd85004756;
            4:  v = 34'sd42667331;
            5:  v = 34'sd21354465;
            6:  v = 34'sd10679838;
            7:  v = 34'sd5340245;
            8:  v = 34'sd2670163;
            9:  v = 34'sd1335086;
            10: v = 34'sd667544;
            11: v = 34'sd333772;
            12: v = 34'sd166886;
            13: v = 34'sd83443;
            14: v = 34'sd41721;
            15: v = 34'sd20860;
            16: v = 34'sd10430;
            17: v = 34'sd5215;
            18: v = 34'sd2607;
            19: v = 34'sd1303;
            20: v = 34'sd651;
            21: v = 34'sd325;
            22: v = 34'sd162;
            23: v = 34'sd81;
            24: v = 34'sd40;
            25: v = 34'sd20;
            26: v = 34'sd10;
            27: v = 34'sd5;
            28: v = 34'sd2;
            29: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // fold an angle into [-1/4, 1/4] turn and load the cordic start vector
    function automatic t_cordic rot_start(input logic [31:0] u);
        t_cordic c;
        logic signed [CW-1:0] z;
        z     = CW'($signed(u));
        c.x   = CORDIC_GAIN_Q30;
        c.y   = '0;
        c.tag = 1'b0;
        if (z > QUARTER_TURN) begin
            z     = z - HALF_TURN_S;
            c.tag = 1'b1;
        end else if (z < -QUARTER_TURN) begin
            z     = z + HALF_TURN_S;
            c.tag = 1'b1;
        end
        c.z = z;
        return c;
    endfunction

endpackage

// ===== design/csad_cordic_cell.sv =====
module csad_cordic_cell #(
    parameter int STEP      = 0,
    parameter bit VECTORING = 1'b0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  csad_pkg::t_cordic i_d,
    output csad_pkg::t_cordic o_q
);
    import csad_pkg::*;

    localparam logic signed [CW-1:0] ANGLE = atan_at(STEP);

    logic signed [CW-1:0] dx, dy;
    logic                 sub;
    t_cordic              n_q, r_q;

    always_comb begin
        dx  = i_d.y >>> STEP;
        dy  = i_d.x >>> STEP;
        sub = VECTORING ? (i_d.y < 0) : (i_d.z >= 0);
        n_q.tag = i_d.tag;
        if (sub) begin
            n_q.x = i_d.x - dx;
            n_q.y = i_d.y + dy;
            n_q.z = i_d.z - ANGLE;
        end else begin
            n_q.x = i_d.x + dx;
            n_q.y = i_d.y - dy;
            n_q.z = i_d.z + ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_q <= n_q;
    end

    assign o_q = r_q;
endmodule

// ===== design/csad_root_cell.sv =====
module csad_root_cell #(
    parameter int STEP = 0
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  csad_pkg::t_root i_d,
    output csad_pkg::t_root o_q
);
    import csad_pkg::*;

    localparam logic [63:0] BIT = 64'd1 << (62 - 2*STEP);

    logic [63:0] trial;
    t_root       n_q, r_q;

    always_comb begin
        trial   = i_d.root + BIT;
        n_q.tag = i_d.tag;
        if (i_d.rem >= trial) begin
            n_q.rem  = i_d.rem - trial;
            n_q.root = (i_d.root >> 1) + BIT;
        end else begin
            n_q.rem  = i_d.rem;
            n_q.root = i_d.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_q <= n_q;
    end

    assign o_q = r_q;
endmodule

// ===== design/cone_search_angular_distance_core.sv =====
// throughput: one position per cycle; every cell of the cordic and root chains
//   holds one item and hands it on each cycle, a stall on the output freezes all
// reset: synchronous active low, clears the three config registers to zero and
//   empties the pipeline; payload registers are not reset
module cone_search_angular_distance_core #(
    parameter int CORDIC_STEPS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // src_ra [31:0], src_dec [63:32]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // ang_distance [31:0], inside_cone [32], zero [39:33]
);
    import csad_pkg::*;

    localparam int N       = CORDIC_STEPS;
    localparam int ROOT_N  = 32;
    // prep + rotation chain + two multiply stages + root chain + vectoring chain + output
    localparam int DEPTH   = 1 + N + 2 + ROOT_N + N + 1;

    // config registers
    logic [31:0] r_centre_ra, r_centre_dec, r_cone_radius;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre_ra   <= '0;
            r_centre_dec  <= '0;
            r_cone_radius <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CENTRE_RA:   r_centre_ra   <= i_cfg_data;
                CFG_CENTRE_DEC:  r_centre_dec  <= i_cfg_data;
                CFG_CONE_RADIUS: r_cone_radius <= i_cfg_data;
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // whole pipeline advances unless the output register holds an untaken result
    logic en, accept;
    logic [DEPTH-1:0] r_vld;

    assign en            = !r_vld[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], accept};
        end
    end

    // prep: half differences and the two latitudes, folded for the cordic
    logic [31:0] src_ra, src_dec, half_dlat, half_dlon;
    t_cordic     r_pre [4];

    assign src_ra    = s_axis_tdata[31:0];
    assign src_dec   = s_axis_tdata[63:32];
    assign half_dlat = (src_dec - r_centre_dec) >> 1;
    assign half_dlon = (src_ra - r_centre_ra) >> 1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pre[0] <= rot_start(half_dlat);
            r_pre[1] <= rot_start(half_dlon);
            r_pre[2] <= rot_start(r_centre_dec);
            r_pre[3] <= rot_start(src_dec);
        end
    end

    // four rotation chains side by side
    t_cordic w_rot [4][N+1];

    for (genvar c = 0; c < 4; c++) begin : g_rot
        assign w_rot[c][0] = r_pre[c];
        for (genvar k = 0; k < N; k++) begin : g_cell
            csad_cordic_cell #(.STEP(k), .VECTORING(1'b0)) u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_d   (w_rot[c][k]),
                .o_q   (w_rot[c][k+1])
            );
        end
    end

    // undo the half-turn fold: sines of the half differences, cosines of the latitudes
    logic signed [CW-1:0] s1, s2, cc, cs;
    logic signed [67:0]   p_sq1, p_sq2, p_cc;
    logic signed [CW-1:0] r_sq1, r_sq2, r_prod;

    assign s1 = w_rot[0][N].tag ? -w_rot[0][N].y : w_rot[0][N].y;
    assign s2 = w_rot[1][N].tag ? -w_rot[1][N].y : w_rot[1][N].y;
    assign cc = w_rot[2][N].tag ? -w_rot[2][N].x : w_rot[2][N].x;
    assign cs = w_rot[3][N].tag ? -w_rot[3][N].x : w_rot[3][N].x;

    assign p_sq1 = s1 * s1;
    assign p_sq2 = s2 * s2;
    assign p_cc  = cc * cs;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq1  <= CW'(p_sq1 >>> 30);
            r_sq2  <= CW'(p_sq2 >>> 30);
            r_prod <= CW'(p_cc >>> 30);
        end
    end

    // haversine term a, clamped to [0, 1] in q30
    logic signed [67:0] p_a;
    logic signed [34:0] a_sum;
    logic [30:0]        r_a;
    logic               r_a_one;

    assign p_a   = r_prod * r_sq2;
    assign a_sum = 35'(r_sq1) + 35'(p_a >>> 30);

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (a_sum < 0) begin
                r_a     <= '0;
                r_a_one <= 1'b0;
            end else if (a_sum >= 35'(ONE_Q30)) begin
                r_a     <= ONE_Q30;
                r_a_one <= 1'b1;
            end else begin
                r_a     <= a_sum[30:0];
                r_a_one <= 1'b0;
            end
        end
    end

    // two root chains: sqrt(a) and sqrt(1-a), both scaled by 2^30
    t_root w_ry [ROOT_N+1];
    t_root w_rx [ROOT_N+1];

    assign w_ry[0].rem  = 64'(r_a) << 30;
    assign w_ry[0].root = '0;
    assign w_ry[0].tag  = r_a_one;
    assign w_rx[0].rem  = 64'(ONE_Q30 - r_a) << 30;
    assign w_rx[0].root = '0;
    assign w_rx[0].tag  = r_a_one;

    for (genvar k = 0; k < ROOT_N; k++) begin : g_root
        csad_root_cell #(.STEP(k)) u_ry (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (w_ry[k]),
            .o_q   (w_ry[k+1])
        );
        csad_root_cell #(.STEP(k)) u_rx (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (w_rx[k]),
            .o_q   (w_rx[k+1])
        );
    end

    // vectoring chain gives atan2(sqrt(a), sqrt(1-a)); tag carries the a == 1 case
    t_cordic w_vec [N+1];

    assign w_vec[0].x   = {3'b000, w_rx[ROOT_N].root[30:0]};
    assign w_vec[0].y   = {3'b000, w_ry[ROOT_N].root[30:0]};
    assign w_vec[0].z   = '0;
    assign w_vec[0].tag = w_ry[ROOT_N].tag && w_rx[ROOT_N].tag;

    for (genvar k = 0; k < N; k++) begin : g_vec
        csad_cordic_cell #(.STEP(k), .VECTORING(1'b1)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (w_vec[k]),
            .o_q   (w_vec[k+1])
        );
    end

    // output register: clamp to a quarter turn, double, compare with the radius
    logic signed [CW-1:0] z_fin;
    logic [31:0]          ang_dist;
    logic [31:0]          r_dist;
    logic                 r_inside;

    assign z_fin = w_vec[N].z;

    always_comb begin
        if (w_vec[N].tag)              ang_dist = HALF_TURN;
        else if (z_fin < 0)            ang_dist = '0;
        else if (z_fin > QUARTER_TURN) ang_dist = HALF_TURN;
        else                           ang_dist = {z_fin[30:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dist   <= ang_dist;
            r_inside <= ang_dist < r_cone_radius;
        end
    end

    assign m_axis_tvalid = r_vld[DEPTH-1];
    assign m_axis_tdata  = {7'b0, r_inside, r_dist};

    // distance never exceeds half a turn
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:0] <= HALF_TURN))
        else $error("distance above half turn");

    // inside flag agrees with the configured radius
    a_inside_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[32] == (m_axis_tdata[31:0] < r_cone_radius)))
        else $error("inside flag disagrees with radius");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule
